// ----- rtl/mtba_pkg.sv -----
package mtba_pkg;

	// Fixed field widths
	localparam int STEPS_W  = 8;
	localparam int PULSE_W  = 8;
	localparam int TOTAL_W  = 14;
	localparam int BUCKET_W = 3;
	localparam int AVG_W    = 8;

	localparam int PULSE_MAX = (1 << PULSE_W) - 1;

	// Hour step total saturates here
	localparam logic [TOTAL_W-1:0] STEP_LIMIT = {TOTAL_W{1'b1}};

	// Controller to datapath commands
	typedef struct packed {
		logic accumulate;   // take the accepted sample
		logic div_start;    // launch divide for current bucket
		logic out_load;     // load result register
		logic next_bucket;  // advance emit index
		logic clear_hour;   // wipe hour state
	} mtba_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_done;
		logic out_free;
		logic last_bucket;
	} mtba_status_t;

endpackage

// ----- rtl/mtba_divider.sv -----
module mtba_divider
	#(
		parameter int NUM_W = 12,
		parameter int DEN_W = 4
	)
	(
		input  logic             clk,
		input  logic             arst_n,
		input  logic             start,
		input  logic [NUM_W-1:0] num,
		input  logic [DEN_W-1:0] den,
		output logic             done,
		output logic [NUM_W-1:0] quot
	);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           ge;

	// One restoring step: bring down the next numerator bit
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	// Control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Data: quotient bits shift in where numerator bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

// ----- rtl/mtba_datapath.sv -----
module mtba_datapath
	import mtba_pkg::*;
	#(
		parameter int BUCKET_COUNT       = 6,
		parameter int SAMPLES_PER_BUCKET = 10,
		parameter int MAX_SAMPLES        = 60
	)
	(
		input  logic                clk,
		input  logic                arst_n,
		input  mtba_cmd_t           cmd,
		output mtba_status_t        status,
		input  logic [STEPS_W-1:0]  minute_steps,
		input  logic [PULSE_W-1:0]  minute_pulse,
		input  logic                sample_invalid,
		output logic                out_valid,
		input  logic                out_ready,
		output logic [BUCKET_W-1:0] bucket_number,
		output logic [AVG_W-1:0]    pulse_average,
		output logic [TOTAL_W-1:0]  hour_step_total,
		output logic                final_bucket
	);

	localparam int POS_W = $clog2(MAX_SAMPLES + 1);
	localparam int SUB_W = (SAMPLES_PER_BUCKET > 1) ? $clog2(SAMPLES_PER_BUCKET) : 1;
	localparam int BKT_W = $clog2(BUCKET_COUNT + 1);
	localparam int IDX_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
	localparam int SUM_W = $clog2(SAMPLES_PER_BUCKET * PULSE_MAX + 1);
	localparam int CNT_W = $clog2(SAMPLES_PER_BUCKET + 1);

	localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_SAMPLES);
	localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(SAMPLES_PER_BUCKET - 1);
	localparam logic [BKT_W-1:0] BKT_OUT  = BKT_W'(BUCKET_COUNT);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUCKET_COUNT - 1);

	// Hour state
	logic [POS_W-1:0]   pos_q;
	logic [SUB_W-1:0]   sub_q;
	logic [BKT_W-1:0]   bkt_q;
	logic [TOTAL_W-1:0] step_q;
	logic [SUM_W-1:0]   sums_q   [BUCKET_COUNT];
	logic [CNT_W-1:0]   counts_q [BUCKET_COUNT];

	// Emit side
	logic [IDX_W-1:0]   emit_q;
	logic               den_zero_q;
	logic               out_valid_q;
	logic [BUCKET_W-1:0] bucket_q;
	logic [AVG_W-1:0]   avg_q;
	logic [TOTAL_W-1:0] total_q;
	logic               final_q;

	logic               pos_full;
	logic               bkt_in;
	logic [IDX_W-1:0]   rd_idx;
	logic [SUM_W-1:0]   rd_sum;
	logic [CNT_W-1:0]   rd_cnt;
	logic [TOTAL_W:0]   step_next;
	logic               div_done;
	logic [SUM_W-1:0]   quot;

	// Single read port: bucket in progress while accumulating, emit index otherwise
	always_comb begin
		pos_full  = (pos_q == POS_MAX);
		bkt_in    = (bkt_q < BKT_OUT);
		rd_idx    = cmd.accumulate ? bkt_q[IDX_W-1:0] : emit_q;
		rd_sum    = sums_q[rd_idx];
		rd_cnt    = counts_q[rd_idx];
		step_next = {1'b0, step_q} + (TOTAL_W + 1)'(minute_steps);
	end

	// Position, bucket tracking and step total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			sub_q  <= '0;
			bkt_q  <= '0;
			step_q <= '0;
		end else if (cmd.clear_hour) begin
			pos_q  <= '0;
			sub_q  <= '0;
			bkt_q  <= '0;
			step_q <= '0;
		end else if (cmd.accumulate && !pos_full) begin
			pos_q <= pos_q + POS_W'(1);
			if (sub_q == SUB_LAST) begin
				sub_q <= '0;
				if (bkt_q != BKT_OUT) begin
					bkt_q <= bkt_q + BKT_W'(1);
				end
			end else begin
				sub_q <= sub_q + SUB_W'(1);
			end
			if (!sample_invalid) begin
				step_q <= step_next[TOTAL_W] ? STEP_LIMIT : step_next[TOTAL_W-1:0];
			end
		end
	end

	// Per-bucket pulse sums and reading counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUCKET_COUNT; i++) begin
				sums_q[i]   <= '0;
				counts_q[i] <= '0;
			end
		end else if (cmd.clear_hour) begin
			for (int i = 0; i < BUCKET_COUNT; i++) begin
				sums_q[i]   <= '0;
				counts_q[i] <= '0;
			end
		end else if (cmd.accumulate && !pos_full && !sample_invalid &&
				minute_pulse != '0 && bkt_in) begin
			sums_q[rd_idx]   <= rd_sum + SUM_W'(minute_pulse);
			counts_q[rd_idx] <= rd_cnt + CNT_W'(1);
		end
	end

	mtba_divider #(
		.NUM_W(SUM_W),
		.DEN_W(CNT_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (rd_sum),
		.den   (rd_cnt),
		.done  (div_done),
		.quot  (quot)
	);

	// Emit index and empty-bucket flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= '0;
		end else if (cmd.clear_hour) begin
			emit_q <= '0;
		end else if (cmd.next_bucket) begin
			emit_q <= emit_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			den_zero_q <= (rd_cnt == '0);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			bucket_q <= BUCKET_W'(emit_q);
			avg_q    <= den_zero_q ? '0 : quot[AVG_W-1:0];
			total_q  <= step_q;
			final_q  <= (emit_q == IDX_LAST);
		end
	end

	assign status.div_done    = div_done;
	assign status.out_free    = !out_valid_q || out_ready;
	assign status.last_bucket = (emit_q == IDX_LAST);

	assign out_valid       = out_valid_q;
	assign bucket_number   = bucket_q;
	assign pulse_average   = avg_q;
	assign hour_step_total = total_q;
	assign final_bucket    = final_q;

endmodule

// ----- rtl/mtba_controller.sv -----
module mtba_controller
	import mtba_pkg::*;
	(
		input  logic         clk,
		input  logic         arst_n,
		input  logic         in_valid,
		output logic         in_ready,
		input  logic         hour_done,
		input  mtba_status_t status,
		output mtba_cmd_t    cmd
	);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_START,
		ST_DIV_RUN,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:      cmd.accumulate = accept;
			ST_DIV_START: cmd.div_start  = 1'b1;
			ST_DIV_RUN:   cmd            = '0;
			ST_EMIT: begin
				cmd.out_load    = status.out_free;
				cmd.clear_hour  = status.out_free && status.last_bucket;
				cmd.next_bucket = status.out_free && !status.last_bucket;
			end
			default:      cmd            = '0;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && hour_done) begin
						state_q <= ST_DIV_START;
					end
				end
				ST_DIV_START: state_q <= ST_DIV_RUN;
				ST_DIV_RUN: begin
					if (status.div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (status.out_free) begin
						state_q <= status.last_bucket ? ST_IDLE : ST_DIV_START;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/minute_to_bucket_averager_unit.sv -----
// Ordinary minute sample: accepted while idle; the next sample may follow the cycle after.
// Sample marked hour_done: one result per bucket; each bucket takes a divide in the
// shared bit-serial divider, and input is not taken again until the last bucket's
// result is loaded. The first result is loaded from ST_EMIT after ST_DIV_START and
// ST_DIV_RUN; output stalls add on.
// arst_n low clears all hour sums, counts, position and the result valid at once.
module minute_to_bucket_averager_unit
	import mtba_pkg::*;
	#(
		parameter int BUCKET_COUNT       = 6,
		parameter int SAMPLES_PER_BUCKET = 10,
		parameter int MAX_SAMPLES        = 60
	)
	(
		input  logic                clk,
		input  logic                arst_n,
		input  logic                in_valid,
		output logic                in_ready,
		input  logic [STEPS_W-1:0]  minute_steps,
		input  logic [PULSE_W-1:0]  minute_pulse,
		input  logic                sample_invalid,
		input  logic                hour_done,
		output logic                out_valid,
		input  logic                out_ready,
		output logic [BUCKET_W-1:0] bucket_number,
		output logic [AVG_W-1:0]    pulse_average,
		output logic [TOTAL_W-1:0]  hour_step_total,
		output logic                final_bucket
	);

	mtba_cmd_t    cmd;
	mtba_status_t status;

	mtba_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.hour_done(hour_done),
		.status   (status),
		.cmd      (cmd)
	);

	mtba_datapath #(
		.BUCKET_COUNT      (BUCKET_COUNT),
		.SAMPLES_PER_BUCKET(SAMPLES_PER_BUCKET),
		.MAX_SAMPLES       (MAX_SAMPLES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.minute_steps   (minute_steps),
		.minute_pulse   (minute_pulse),
		.sample_invalid (sample_invalid),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.bucket_number  (bucket_number),
		.pulse_average  (pulse_average),
		.hour_step_total(hour_step_total),
		.final_bucket   (final_bucket)
	);

endmodule

// ----- rtl/mtba_checker.sv -----
module mtba_checker
	import mtba_pkg::*;
	#(
		parameter int BUCKET_COUNT = 6
	)
	(
		input logic                clk,
		input logic                arst_n,
		input logic                in_valid,
		input logic                in_ready,
		input logic                hour_done,
		input logic                out_valid,
		input logic                out_ready,
		input logic [BUCKET_W-1:0] bucket_number,
		input logic [AVG_W-1:0]    pulse_average,
		input logic [TOTAL_W-1:0]  hour_step_total,
		input logic                final_bucket
	);

	localparam logic [BUCKET_W-1:0] LAST_NUM = BUCKET_W'(BUCKET_COUNT - 1);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bucket_number) &&
			$stable(pulse_average) && $stable(hour_step_total) && $stable(final_bucket))
		else $error("result changed while stalled");

	// Final result carries the last bucket number
	a_final_num: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && final_bucket |-> bucket_number == LAST_NUM)
		else $error("final result on wrong bucket");

	// Step total is shared by all results of one hour
	a_total_same: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !final_bucket |=> $stable(hour_step_total))
		else $error("step total changed within an hour");

	// End-of-hour request closes the input side
	a_busy_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && hour_done |=> !in_ready)
		else $error("input taken during bucket emission");

endmodule

bind minute_to_bucket_averager_unit mtba_checker #(.BUCKET_COUNT(BUCKET_COUNT)) u_chk (.*);
